// ===== src/byte_level_piece_decode_top_defines.svh =====
// Assertion macros shared by the piece decoder modules.
`ifndef BYTE_LEVEL_PIECE_DECODE_TOP_DEFINES_SVH
`define BYTE_LEVEL_PIECE_DECODE_TOP_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define BLDEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define BLDEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bldec_pkg.sv =====
// Types, constants and decode functions of the byte-level piece decoder.
package bldec_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned MAX_GROUP   = 4;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  localparam logic [10:0] PRINT_A_LO     = 11'h0A1;
  localparam logic [10:0] PRINT_A_HI     = 11'h0AC;
  localparam logic [10:0] PRINT_B_LO     = 11'h0AE;
  localparam logic [10:0] PRINT_B_HI     = 11'h0FF;
  localparam logic [10:0] NONPRINT_BASE  = 11'h100;
  localparam logic [10:0] NONPRINT_END   = 11'h144;

  localparam logic [6:0] NONPRINT_LOW_CNT = 7'd33;
  localparam logic [6:0] NONPRINT_MID_END = 7'd67;
  localparam logic [7:0] DEL_BYTE         = 8'h7F;
  localparam logic [7:0] SOFT_HYPHEN      = 8'hAD;

  typedef struct packed {
    logic [MAX_GROUP-1:0][7:0] data;
    logic [1:0]                last_idx;
    logic                      piece_end;
  } bldec_grp_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] value;
  } bldec_dec_t;

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd1;
    if ((c & LEAD2_MASK) == LEAD2_CODE) len = 3'd2;
    else if ((c & LEAD3_MASK) == LEAD3_CODE) len = 3'd3;
    else if ((c & LEAD4_MASK) == LEAD4_CODE) len = 3'd4;
    return len;
  endfunction

  function automatic logic [7:0] nonprint_byte(input logic [6:0] idx);
    logic [7:0] b;
    if (idx < NONPRINT_LOW_CNT) b = {1'b0, idx};
    else if (idx < NONPRINT_MID_END) b = DEL_BYTE + {1'b0, idx} - {1'b0, NONPRINT_LOW_CNT};
    else b = SOFT_HYPHEN;
    return b;
  endfunction

  function automatic bldec_dec_t decode_pair(input logic [7:0] g0, input logic [7:0] g1);
    bldec_dec_t r;
    logic [10:0] cp;
    cp      = {g0[4:0], g1[5:0]};
    r.ok    = 1'b0;
    r.value = g0;
    if ((g0 & LEAD2_MASK) == LEAD2_CODE && (g1 & CONT_MASK) == CONT_CODE) begin
      if ((cp >= PRINT_A_LO && cp <= PRINT_A_HI) || (cp >= PRINT_B_LO && cp <= PRINT_B_HI)) begin
        r.ok    = 1'b1;
        r.value = cp[7:0];
      end else if (cp >= NONPRINT_BASE && cp < NONPRINT_END) begin
        r.ok    = 1'b1;
        r.value = nonprint_byte(cp[6:0]);
      end
    end
    return r;
  endfunction

endpackage

// ===== src/bldec_front.sv =====
// Front end: assembles byte groups and turns each finished group into an output word list.
`include "byte_level_piece_decode_top_defines.svh"

module bldec_front import bldec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       piece_end_i,
  input  logic       full_i,
  output logic       push_o,
  output bldec_grp_t push_data_o
);

  logic [7:0]      pend_q [3];
  logic [1:0]      pend_cnt_q, pend_cnt_d;
  logic [2:0]      grp_len_q, grp_len_d;
  logic            pend_wr;
  logic [1:0]      pend_wr_idx;
  logic [3:0][7:0] grp_bytes, items;
  logic [2:0]      item_cnt, lead_in, lead_mid, n_new;
  bldec_dec_t      dec_full, dec_tail;
  logic            accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign lead_in    = lead_len(in_byte_i);
  assign n_new      = 3'(pend_cnt_q) + 3'd1;

  always_comb begin
    grp_bytes[0] = pend_q[0];
    grp_bytes[1] = pend_q[1];
    grp_bytes[2] = pend_q[2];
    grp_bytes[3] = 8'h00;
    grp_bytes[pend_cnt_q] = in_byte_i;
  end

  assign dec_full = decode_pair(grp_bytes[0], grp_bytes[1]);
  assign dec_tail = decode_pair(grp_bytes[1], grp_bytes[2]);
  assign lead_mid = lead_len(grp_bytes[1]);

  always_comb begin
    items       = grp_bytes;
    item_cnt    = 3'd0;
    pend_cnt_d  = pend_cnt_q;
    grp_len_d   = grp_len_q;
    pend_wr     = 1'b0;
    pend_wr_idx = pend_cnt_q;
    if (grp_len_q == 3'd0 || pend_cnt_q == 2'd0) begin
      if (lead_in > 3'd1 && !piece_end_i) begin
        pend_wr     = 1'b1;
        pend_wr_idx = 2'd0;
        pend_cnt_d  = 2'd1;
        grp_len_d   = lead_in;
      end else begin
        items[0] = in_byte_i;
        item_cnt = 3'd1;
      end
    end else begin
      pend_cnt_d = 2'd0;
      grp_len_d  = 3'd0;
      if (n_new >= grp_len_q) begin
        item_cnt = grp_len_q;
        if (grp_len_q == 3'd2 && dec_full.ok) begin
          items[0] = dec_full.value;
          item_cnt = 3'd1;
        end
      end else if (piece_end_i) begin
        item_cnt = n_new;
        if (n_new == 3'd3 && lead_mid == 3'd2 && dec_tail.ok) begin
          items[1] = dec_tail.value;
          item_cnt = 3'd2;
        end
      end else begin
        pend_wr    = 1'b1;
        pend_cnt_d = n_new[1:0];
        grp_len_d  = grp_len_q;
      end
    end
  end

  assign push_o                = accept && (item_cnt != 3'd0);
  assign push_data_o.data      = items;
  assign push_data_o.last_idx  = 2'(item_cnt - 3'd1);
  assign push_data_o.piece_end = piece_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= 2'd0;
      grp_len_q  <= 3'd0;
      pend_q[0]  <= 8'h00;
      pend_q[1]  <= 8'h00;
      pend_q[2]  <= 8'h00;
    end else if (accept) begin
      pend_cnt_q <= pend_cnt_d;
      grp_len_q  <= grp_len_d;
      if (pend_wr) pend_q[pend_wr_idx] <= in_byte_i;
    end
  end

  `BLDEC_ASSERT_IMP(a_push_on_accept, push_o, in_valid_i && in_ready_o, "Push without an accepted word.")
  `BLDEC_ASSERT_IMP(a_open_consistent, 1'b1, (pend_cnt_q != 2'd0) == (grp_len_q != 3'd0), "Open group state is inconsistent.")
  `BLDEC_ASSERT_IMP(a_count_below_len, pend_cnt_q != 2'd0, 3'(pend_cnt_q) < grp_len_q, "Open group holds too many bytes.")

endmodule

// ===== src/bldec_fifo.sv =====
// Queue of finished group records between the front end and the back end.
`include "byte_level_piece_decode_top_defines.svh"

module bldec_fifo import bldec_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bldec_grp_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       head_valid_o,
  output bldec_grp_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bldec_grp_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;
  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop) rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  `BLDEC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= FullCnt, "Queue count exceeds depth.")
  `BLDEC_ASSERT_IMP(a_no_push_full, push_i, !full_o, "Word record pushed into a full queue.")

endmodule

// ===== src/bldec_back.sv =====
// Back end: sends the words of each queued group out one at a time through an output register.
`include "byte_level_piece_decode_top_defines.svh"

module bldec_back import bldec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  bldec_grp_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_piece_end_o,
  output logic       run_last_o
);

  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic [7:0] byte_q;
  logic       pend_q, last_q;
  logic       load, at_last;

  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && at_last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.data[idx_q];
      last_q <= at_last;
      pend_q <= at_last && head_i.piece_end;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign out_piece_end_o = pend_q;
  assign run_last_o      = last_q;

  `BLDEC_ASSERT_NXT(a_pop_sets_last, pop_o, valid_q && last_q && idx_q == 2'd0,
                    "A group was retired without its last word in the output register.")

endmodule

// ===== src/byte_level_piece_decode_top.sv =====
// Top level of the byte-level piece decoder.
//
//   Channel | Handshake                     | Payload
//   input   | in_valid_i / in_ready_o       | in_byte_i, piece_end_i
//   output  | out_valid_o / out_ready_i     | out_byte_o, out_piece_end_o, run_last_o
//
// One input word is accepted per cycle while the group queue has room.
// The back end sends one output word per cycle from the queue head while the output is ready,
// so a group of up to four words leaves as a burst; the queue absorbs these bursts.
// After its input word is accepted, a result is written into the queue, then into the output register.
// Reset clears the open group, the queue and the output register.
// A stalled output fills the queue, and input stalls only when the queue is full.
module byte_level_piece_decode_top import bldec_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       piece_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_piece_end_o,
  output logic       run_last_o
);

  logic       push, full, pop, head_valid;
  bldec_grp_t push_data, head;

  bldec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .piece_end_i (piece_end_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bldec_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  bldec_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .out_piece_end_o (out_piece_end_o),
    .run_last_o      (run_last_o)
  );

endmodule
